// ----- src/complete_elliptic_integrals_defines.svh -----
// Assertion macros for the complete elliptic integral block.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef COMPLETE_ELLIPTIC_INTEGRALS_DEFINES_SVH
`define COMPLETE_ELLIPTIC_INTEGRALS_DEFINES_SVH

// same-cycle implication
`define CEI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cei_pkg.sv -----
// Package for the complete elliptic integral block: constants, item record,
// coefficient tables and fixed-point conversion. No dependencies.
package cei_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int IF_BITS       = 56;
    localparam int WORD_W        = 64;
    localparam int EXP_W         = 6;
    localparam logic [63:0] DEC_SCALE = 64'd1000000000000000000;

    localparam int TAB_KP = 0;
    localparam int TAB_KQ = 1;
    localparam int TAB_EP = 2;
    localparam int TAB_EQ = 3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_DOMAIN = 2'd1;
    localparam logic [1:0] STAT_SING   = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic                 want_e;
        logic                 spec;
        logic [1:0]           status;
        logic [EXP_W-1:0]     e;
        logic [IF_BITS-1:0]   frac;
        logic [WORD_W-1:0]    x;
        logic [WORD_W-1:0]    g;
        logic [WORD_W-1:0]    p;
        logic [WORD_W-1:0]    q;
    } cei_item_t;

    // coefficients scaled by 10^18, highest power first
    function automatic logic [63:0] dec_coef(input int tab, input int j);
        logic [63:0] c;
        c = 64'd0;
        case (tab)
            TAB_KP:
                case (j)
                    0: c = 64'd137982864606273;
                    1: c = 64'd2280257240058756;
                    2: c = 64'd7974040132204152;
                    3: c = 64'd9858213790212260;
                    4: c = 64'd6874896874499499;
                    5: c = 64'd6189010336376876;
                    6: c = 64'd8790782739527438;
                    7: c = 64'd14938044891680525;
                    8: c = 64'd30885146524671200;
                    9: c = 64'd96573590281169013;
                    10: c = 64'd1386294361119890625;
                    default: c = 64'd0;
                endcase
            TAB_KQ:
                case (j)
                    0: c = 64'd29407895504860;
                    1: c = 64'd914184723865917;
                    2: c = 64'd5940583037531678;
                    3: c = 64'd15485051664976240;
                    4: c = 64'd23908960271592489;
                    5: c = 64'd30120471522760405;
                    6: c = 64'd37377431417382323;
                    7: c = 64'd48828034757099824;
                    8: c = 64'd70312499696395747;
                    9: c = 64'd124999999999870820;
                    10: c = 64'd500000000000000000;
                    default: c = 64'd0;
                endcase
            TAB_EP:
                case (j)
                    0: c = 64'd153552577301013;
                    1: c = 64'd2508884921636021;
                    2: c = 64'd8687868165658896;
                    3: c = 64'd10735094905607619;
                    4: c = 64'd7773954925167871;
                    5: c = 64'd7583952894135147;
                    6: c = 64'd11568843681057413;
                    7: c = 64'd21831799601555725;
                    8: c = 64'd56805194561786055;
                    9: c = 64'd443147180560990851;
                    10: c = 64'd1000000000000000003;
                    default: c = 64'd0;
                endcase
            TAB_EQ:
                // the tenth step is the extra multiply by x, with nothing added
                case (j)
                    0: c = 64'd32795489857649;
                    1: c = 64'd1009627926793567;
                    2: c = 64'd6506094899769275;
                    3: c = 64'd16886216399331132;
                    4: c = 64'd26176974245449366;
                    5: c = 64'd33483390488822492;
                    6: c = 64'd42718092651893151;
                    7: c = 64'd58593663447110106;
                    8: c = 64'd93749999719764428;
                    9: c = 64'd249999999999888314;
                    default: c = 64'd0;
                endcase
            default: c = 64'd0;
        endcase
        return c;
    endfunction

    // round-half-up(a * 2^56 / 10^18); only ever called on constants
    function automatic logic [63:0] dec_to_q(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] q;
        logic        b;
        int          i;
        r = 64'd0;
        q = 64'd0;
        for (i = 63 + IF_BITS + 1; i >= 0; i--) begin
            b = 1'b0;
            if (i >= IF_BITS + 1)
                b = a[i-(IF_BITS+1)];
            r = {r[62:0], b};
            q = {q[62:0], 1'b0};
            if (r >= DEC_SCALE)
            begin
                r = r - DEC_SCALE;
                q[0] = 1'b1;
            end
        end
        return (q + 64'd1) >> 1;
    endfunction

    localparam logic [63:0] LN2_Q = dec_to_q(64'd693147180559945309);

endpackage

// ----- src/complete_elliptic_integrals.sv -----
// Complete elliptic integrals K and E of the complementary parameter m1.
// Most of the pipeline is the chain of 56 log cells; one transaction per cycle,
// and the whole chain holds while a result waits at the output.
// Reset clears all valid flags; the pipeline then accepts at once.
// Depends on cei_pkg, cei_mulq, cei_norm_cell, cei_cell and the defines header.
`include "complete_elliptic_integrals_defines.svh"
module complete_elliptic_integrals
    import cei_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [FRAC_BITS+1:0] m_comp,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS+4:0] integral_value,
    output logic [1:0]           status
);

    localparam int SH    = IF_BITS - FRAC_BITS;
    localparam int NS    = $clog2(FRAC_BITS + 1);
    localparam int OUT_W = FRAC_BITS + 5;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 64'd1;
    localparam logic [63:0] C0_KP = dec_to_q(dec_coef(TAB_KP, 0));
    localparam logic [63:0] C0_KQ = dec_to_q(dec_coef(TAB_KQ, 0));
    localparam logic [63:0] C0_EP = dec_to_q(dec_coef(TAB_EP, 0));
    localparam logic [63:0] C0_EQ = dec_to_q(dec_coef(TAB_EQ, 0));

    logic       en;
    cei_item_t  entry_reg, entry_next;
    cei_item_t  norm_item [NS+1];
    cei_item_t  step_item [IF_BITS+1];
    cei_item_t  t1_reg, t2_reg, t3_reg;
    logic [WORD_W-1:0] ln_arg, nl, nl_reg, fin_prod;
    logic [WORD_W-1:0] val, rounded, res;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  value_reg, value_next;
    logic [1:0]        status_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        entry_next        = '0;
        entry_next.valid  = in_valid;
        entry_next.want_e = req_type;
        entry_next.x      = 64'(m_comp[FRAC_BITS:0]) << SH;
        entry_next.g      = 64'(m_comp[FRAC_BITS:0]) << SH;
        entry_next.p      = req_type ? C0_EP : C0_KP;
        entry_next.q      = req_type ? C0_EQ : C0_KQ;
        entry_next.status = STAT_OK;
        if (m_comp[FRAC_BITS+1] || m_comp[FRAC_BITS:0] > ONE)
        begin
            entry_next.spec   = 1'b1;
            entry_next.status = STAT_DOMAIN;
        end
        else if (m_comp[FRAC_BITS:0] == '0)
        begin
            entry_next.spec   = 1'b1;
            entry_next.status = req_type ? STAT_OK : STAT_SING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg.valid <= 1'b0;
        else if (en)
            entry_reg <= entry_next;
    end

    assign norm_item[0] = entry_reg;

    generate
        for (genvar k = 0; k < NS; k++)
        begin : g_norm
            cei_norm_cell #(.SHIFT(1 << (NS - 1 - k))) u_norm (
                .clk(clk), .rst_n(rst_n), .en(en),
                .item_in(norm_item[k]), .item_out(norm_item[k+1])
            );
        end
    endgenerate

    assign step_item[0] = norm_item[NS];

    generate
        for (genvar j = 0; j < IF_BITS; j++)
        begin : g_step
            cei_cell #(.J(j)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .item_in(step_item[j]), .item_out(step_item[j+1])
            );
        end
    endgenerate

    // -log2(m1) = e - f, scaled by ln 2
    assign ln_arg = (64'(step_item[IF_BITS].e) << IF_BITS)
                  - 64'(step_item[IF_BITS].frac);

    cei_mulq u_ln (.clk(clk), .en(en), .a(ln_arg), .b(LN2_Q), .prod(nl));
    cei_mulq u_fin (.clk(clk), .en(en), .a(nl_reg), .b(t2_reg.q), .prod(fin_prod));

    always_comb
    begin
        val     = t3_reg.p + fin_prod;
        rounded = val + (64'd1 << (SH - 1));
        res     = rounded >> SH;
        if (res > OUT_MAX)
            res = OUT_MAX;
        value_next = res[OUT_W-1:0];
        if (t3_reg.spec)
        begin
            case (t3_reg.status)
                STAT_DOMAIN: value_next = '0;
                STAT_SING:   value_next = '1;
                default:     value_next = OUT_W'(ONE);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg.valid  <= 1'b0;
            t2_reg.valid  <= 1'b0;
            t3_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_reg        <= step_item[IF_BITS];
            t2_reg        <= t1_reg;
            t3_reg        <= t2_reg;
            out_valid_reg <= t3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nl_reg     <= nl;
            value_reg  <= value_next;
            status_reg <= t3_reg.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign integral_value = value_reg;
    assign status         = status_reg;

    `CEI_ASSERT_NOW(a_domain_zero, out_valid && status == STAT_DOMAIN, integral_value == '0, "domain error with nonzero value")
    `CEI_ASSERT_NOW(a_sing_max, out_valid && status == STAT_SING, integral_value == '1, "singularity not saturated")
    `CEI_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(integral_value), "stalled result lost")
    `CEI_ASSERT_NOW(a_ready_rule, !out_valid, in_ready, "input refused while output empty")

endmodule

// ----- src/cei_mulq.sv -----
// Rounded Q.56 multiplier: 32x32 partial products registered, then summed.
// Depends on cei_pkg.
module cei_mulq
    import cei_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] prod
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0] sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            lh_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
        end
    end

    assign sum = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
               + {64'd0, ll_reg} + (128'd1 << (IF_BITS - 1));
    assign prod = sum[WORD_W+IF_BITS-1:IF_BITS];

endmodule

// ----- src/cei_norm_cell.sv -----
// Normalising cell: shifts g left by SHIFT when its top SHIFT bits are clear.
// Depends on cei_pkg.
module cei_norm_cell
    import cei_pkg::*;
#(
    parameter int SHIFT = 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cei_item_t item_in,
    output cei_item_t item_out
);

    cei_item_t item_reg, item_next;

    always_comb
    begin
        item_next = item_in;
        if (item_in.g[IF_BITS -: SHIFT] == '0)
        begin
            item_next.g = item_in.g << SHIFT;
            item_next.e = item_in.e + EXP_W'(SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg.valid <= 1'b0;
        else if (en)
            item_reg <= item_next;
    end

    assign item_out = item_reg;

endmodule

// ----- src/cei_cell.sv -----
// Chain cell J: one log2 bit by squaring g, plus Horner step J+1 for J < 10.
// Depends on cei_pkg and cei_mulq.
module cei_cell
    import cei_pkg::*;
#(
    parameter int J = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cei_item_t item_in,
    output cei_item_t item_out
);

    cei_item_t         a_reg, b_reg, b_next;
    logic [WORD_W-1:0] sq;
    logic [WORD_W-1:0] p_new, q_new;

    cei_mulq u_sq (.clk(clk), .en(en), .a(item_in.g), .b(item_in.g), .prod(sq));

    generate
        if (J < 10)
        begin : g_poly
            localparam logic [63:0] C_KP = dec_to_q(dec_coef(TAB_KP, J + 1));
            localparam logic [63:0] C_KQ = dec_to_q(dec_coef(TAB_KQ, J + 1));
            localparam logic [63:0] C_EP = dec_to_q(dec_coef(TAB_EP, J + 1));
            localparam logic [63:0] C_EQ = dec_to_q(dec_coef(TAB_EQ, J + 1));
            logic [WORD_W-1:0] px, qx;
            cei_mulq u_p (.clk(clk), .en(en), .a(item_in.p), .b(item_in.x), .prod(px));
            cei_mulq u_q (.clk(clk), .en(en), .a(item_in.q), .b(item_in.x), .prod(qx));
            assign p_new = px + (a_reg.want_e ? C_EP : C_KP);
            assign q_new = qx + (a_reg.want_e ? C_EQ : C_KQ);
        end
        else
        begin : g_pass
            assign p_new = a_reg.p;
            assign q_new = a_reg.q;
        end
    endgenerate

    always_comb
    begin
        b_next   = a_reg;
        b_next.p = p_new;
        b_next.q = q_new;
        b_next.g = sq;
        if (sq >= (64'd2 << IF_BITS))
        begin
            b_next.g = sq >> 1;
            b_next.frac[IF_BITS-1-J] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg.valid <= 1'b0;
            b_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            a_reg <= item_in;
            b_reg <= b_next;
        end
    end

    assign item_out = b_reg;

endmodule
